// ----- hdl/lzss_pkg.sv -----
// package: shared constants and types for the lzss stream decoder
`default_nettype none
package lzss_pkg;
  localparam int HIST_DEPTH = 4096;
  localparam int HIST_AW = $clog2(HIST_DEPTH);
  localparam int CNT_W = HIST_AW + 1;
  localparam int BYTES_PER_RESULT = 8;
  localparam int MIN_RUN = 3;
  localparam int RUN_W = 9;

  typedef enum logic [1:0] {
    PH_FLAG,
    PH_TOKEN,
    PH_LOW
  } phase_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_READ,
    CS_OUT
  } cstate_t;

  typedef struct packed {
    logic [HIST_AW-1:0] addr;
    logic               wr;
    logic [7:0]         wdata;
  } mem_req_t;
endpackage
`default_nettype wire

// ----- hdl/lzss_hist_mem.sv -----
// module: history memory with one write port and one registered read port
`default_nettype none
module lzss_hist_mem
  import lzss_pkg::*;
(
  input  wire logic               clk,
  input  wire mem_req_t           wreq,
  input  wire logic [HIST_AW-1:0] raddr,
  output logic [7:0]              rdata
);
  logic [7:0] mem [HIST_DEPTH];

  always_ff @(posedge clk) begin
    if (wreq.wr) begin
      mem[wreq.addr] <= wreq.wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- hdl/lzss_stream_decoder.sv -----
// top level: lzss stream decoder with parser, copy sequencer and history memory
// a flag or token high byte gives no result
// a literal's result sits in the output register
// a copy of length n reads the history memory one byte at a time
// (read, then write) and waits on output handshakes
// rst clears parse state, counters and run_bits (to 8); history is not cleared
`default_nettype none
module lzss_stream_decoder
  import lzss_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [3:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] data_byte,
  input  wire logic       stream_start,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte0,
  output logic [7:0]      out_byte1,
  output logic [7:0]      out_byte2,
  output logic [7:0]      out_byte3,
  output logic [7:0]      out_byte4,
  output logic [7:0]      out_byte5,
  output logic [7:0]      out_byte6,
  output logic [7:0]      out_byte7,
  output logic [3:0]      byte_count,
  output logic            last_of_token,
  output logic            bad_offset
);
  logic [3:0]         run_bits;
  phase_t             phase, phase_next;
  cstate_t            cst, cst_next;
  logic [7:0]         flag_bits;
  logic [2:0]         flag_index;
  logic [7:0]         token_high;
  logic [HIST_AW-1:0] wp;
  logic [CNT_W-1:0]   produced;
  logic [HIST_AW:0]   off;
  logic [RUN_W-1:0]   remain;
  logic [7:0]         obuf [BYTES_PER_RESULT];
  logic [3:0]         ocnt;
  logic [7:0]         rdata;
  mem_req_t           wreq;
  logic [HIST_AW-1:0] raddr;

  logic        accept, out_take, out_free;
  phase_t      ph_eff;
  logic [2:0]  fi_eff;
  logic [7:0]  fb_eff;
  logic [HIST_AW-1:0] wp_eff;
  logic [CNT_W-1:0]   pc_eff;
  logic [3:0]  rb;
  logic [15:0] token;
  logic [15:0] tok_off;
  logic [7:0]  run_mask;
  logic [RUN_W-1:0] run_len;
  logic [16:0] off_full;
  logic        is_lit, is_copy, too_far;
  logic [HIST_AW:0] src_sum;
  logic [2:0]  fi_inc;

  assign out_take = out_valid && !out_stall;
  assign out_free = !out_valid || out_take;
  assign in_stall = (cst != CS_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    ph_eff = phase;
    fi_eff = flag_index;
    fb_eff = flag_bits;
    wp_eff = wp;
    pc_eff = produced;
    if (stream_start) begin
      ph_eff = PH_FLAG;
      fi_eff = '0;
      fb_eff = '0;
      wp_eff = '0;
      pc_eff = '0;
    end
    rb       = (run_bits > 4'd8) ? 4'd8 : run_bits;
    token    = {token_high, data_byte};
    tok_off  = token >> rb;
    run_mask = 8'((9'd1 << rb) - 9'd1);
    run_len  = RUN_W'(token[7:0] & run_mask) + RUN_W'(MIN_RUN);
    off_full = 17'(tok_off) + 17'd1;
    too_far  = off_full > 17'(pc_eff);
    is_lit   = (ph_eff == PH_TOKEN) && fb_eff[fi_eff];
    is_copy  = (ph_eff == PH_LOW);
    fi_inc   = fi_eff + 3'd1;
  end

  always_comb begin
    phase_next = ph_eff;
    unique case (ph_eff)
      PH_TOKEN: phase_next = is_lit ? ((fi_inc == 3'd0) ? PH_FLAG : PH_TOKEN) : PH_LOW;
      PH_LOW:   phase_next = (fi_inc == 3'd0) ? PH_FLAG : PH_TOKEN;
      default:  phase_next = PH_TOKEN;
    endcase
  end

  always_comb begin
    cst_next = cst;
    unique case (cst)
      CS_IDLE: if (accept && is_copy && !too_far) cst_next = CS_READ;
      CS_READ: cst_next = CS_OUT;
      CS_OUT: begin
        if (remain == RUN_W'(1) || ocnt == 4'(BYTES_PER_RESULT - 1)) begin
          if (out_free) cst_next = (remain == RUN_W'(1)) ? CS_IDLE : CS_READ;
        end else begin
          cst_next = CS_READ;
        end
      end
      default: cst_next = CS_IDLE;
    endcase
  end

  assign src_sum = {1'b0, wp} + (HIST_AW+1)'(HIST_DEPTH) - off;
  always_comb begin
    raddr = (src_sum >= (HIST_AW+1)'(HIST_DEPTH)) ?
            HIST_AW'(src_sum - (HIST_AW+1)'(HIST_DEPTH)) : src_sum[HIST_AW-1:0];
    wreq.addr  = wp;
    wreq.wr    = 1'b0;
    wreq.wdata = rdata;
    if (cst == CS_IDLE) begin
      wreq.addr  = wp_eff;
      wreq.wr    = accept && is_lit;
      wreq.wdata = data_byte;
    end else if (cst == CS_OUT) begin
      wreq.wr = (remain == RUN_W'(1) || ocnt == 4'(BYTES_PER_RESULT - 1)) ? out_free : 1'b1;
    end
  end

  lzss_hist_mem u_mem (
    .clk  (clk),
    .wreq (wreq),
    .raddr(raddr),
    .rdata(rdata)
  );

  logic wr_done;
  assign wr_done = wreq.wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_bits   <= 4'd8;
      phase      <= PH_FLAG;
      cst        <= CS_IDLE;
      flag_bits  <= '0;
      flag_index <= '0;
      token_high <= '0;
      wp         <= '0;
      produced   <= '0;
      out_valid  <= 1'b0;
      ocnt       <= '0;
      remain     <= '0;
      off        <= '0;
    end else begin
      if (cfg_we) run_bits <= cfg_data;
      cst <= cst_next;
      if (out_take) out_valid <= 1'b0;
      if (wr_done) begin
        wp <= (wp == HIST_AW'(HIST_DEPTH - 1)) ? '0 : wp + 1'b1;
        if (produced < CNT_W'(HIST_DEPTH)) produced <= produced + 1'b1;
      end
      if (accept) begin
        phase      <= phase_next;
        flag_index <= fi_eff;
        flag_bits  <= fb_eff;
        if (!wr_done) begin
          wp       <= wp_eff;
          produced <= pc_eff;
        end else begin
          wp <= (wp_eff == HIST_AW'(HIST_DEPTH - 1)) ? '0 : wp_eff + 1'b1;
          produced <= (pc_eff < CNT_W'(HIST_DEPTH)) ? pc_eff + 1'b1 : pc_eff;
        end
        if (ph_eff == PH_FLAG) begin
          flag_bits  <= data_byte;
          flag_index <= '0;
        end
        if (ph_eff == PH_TOKEN && !is_lit) token_high <= data_byte;
        if (is_lit || is_copy) flag_index <= fi_inc;
        if (is_lit || (is_copy && too_far)) begin
          out_valid     <= 1'b1;
          byte_count    <= is_lit ? 4'd1 : 4'd0;
          last_of_token <= 1'b1;
          bad_offset    <= !is_lit;
          for (int i = 0; i < BYTES_PER_RESULT; i++) obuf[i] <= '0;
          obuf[0] <= is_lit ? data_byte : 8'd0;
        end
        if (is_copy && !too_far) begin
          off    <= off_full[HIST_AW:0];
          remain <= run_len;
          ocnt   <= '0;
          for (int i = 0; i < BYTES_PER_RESULT; i++) obuf[i] <= '0;
        end
      end
      if (cst == CS_OUT && wr_done) begin
        obuf[ocnt[2:0]] <= rdata;
        remain <= remain - 1'b1;
        if (remain == RUN_W'(1) || ocnt == 4'(BYTES_PER_RESULT - 1)) begin
          out_valid     <= 1'b1;
          byte_count    <= ocnt + 4'd1;
          last_of_token <= (remain == RUN_W'(1));
          bad_offset    <= 1'b0;
          ocnt          <= '0;
          for (int i = 0; i < BYTES_PER_RESULT; i++) begin
            if (4'(i) > ocnt) obuf[i] <= '0;
          end
          obuf[ocnt[2:0]] <= rdata;
        end else begin
          ocnt <= ocnt + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cst == CS_OUT && wr_done &&
        (remain == RUN_W'(1) || ocnt == 4'(BYTES_PER_RESULT - 1))) begin
      out_byte0 <= (ocnt == 4'd0) ? rdata : obuf[0];
      out_byte1 <= (ocnt == 4'd1) ? rdata : ((ocnt > 4'd1) ? obuf[1] : 8'd0);
      out_byte2 <= (ocnt == 4'd2) ? rdata : ((ocnt > 4'd2) ? obuf[2] : 8'd0);
      out_byte3 <= (ocnt == 4'd3) ? rdata : ((ocnt > 4'd3) ? obuf[3] : 8'd0);
      out_byte4 <= (ocnt == 4'd4) ? rdata : ((ocnt > 4'd4) ? obuf[4] : 8'd0);
      out_byte5 <= (ocnt == 4'd5) ? rdata : ((ocnt > 4'd5) ? obuf[5] : 8'd0);
      out_byte6 <= (ocnt == 4'd6) ? rdata : ((ocnt > 4'd6) ? obuf[6] : 8'd0);
      out_byte7 <= (ocnt == 4'd7) ? rdata : 8'd0;
    end else if (accept && (is_lit || (is_copy && too_far))) begin
      out_byte0 <= is_lit ? data_byte : 8'd0;
      out_byte1 <= '0;
      out_byte2 <= '0;
      out_byte3 <= '0;
      out_byte4 <= '0;
      out_byte5 <= '0;
      out_byte6 <= '0;
      out_byte7 <= '0;
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (cst != CS_IDLE) |-> !accept) else $error("request taken during copy");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_count <= 4'(BYTES_PER_RESULT))) else $error("byte_count too large");
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && bad_offset) |-> (byte_count == 4'd0 && last_of_token))
    else $error("bad offset result malformed");
`endif
endmodule
`default_nettype wire
